// ----- hdl/ipol_pkg.sv -----
// ----------------------------------------------------------------------------
// ipol_pkg
// Shared types and constants of the IP payload offset locator.
// ----------------------------------------------------------------------------
package ipol_pkg;

   typedef enum logic [2:0] {
      PH_OUTER_IHL   = 3'd0,
      PH_OUTER_PROTO = 3'd1,
      PH_INNER_IHL   = 3'd2,
      PH_INNER_PROTO = 3'd3,
      PH_TCP_OFF     = 3'd4,
      PH_DONE        = 3'd5
   } phase_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_OUT_IHL = 3'd1;
   localparam logic [2:0] ST_BAD_IN_IHL  = 3'd2;
   localparam logic [2:0] ST_BAD_TCP_OFF = 3'd3;
   localparam logic [2:0] ST_BAD_OUT_PRO = 3'd4;
   localparam logic [2:0] ST_BAD_IN_PRO  = 3'd5;
   localparam logic [2:0] ST_TRUNCATED   = 3'd6;

   localparam logic [7:0] PROTO_TCP  = 8'h06;
   localparam logic [7:0] PROTO_UDP  = 8'h11;
   localparam logic [7:0] PROTO_IPIP = 8'h04;

   localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
   localparam logic [7:0] UDP_HDR_BYTES = 8'd8;
   localparam logic [7:0] IP_PROTO_POS  = 8'd9;
   localparam logic [7:0] TCP_OFF_POS   = 8'd12;
   localparam logic [7:0] POS_MAX       = 8'd255;

   typedef struct packed {
      logic       valid;
      logic [2:0] status;
      logic [7:0] payload_offset;
      logic       transport_is_udp;
      logic       tunneled;
   } result_type;

endpackage

// ----- hdl/ipol_parse.sv -----
// ----------------------------------------------------------------------------
// ipol_parse
// Header walk state and the per-byte parse step.
// ----------------------------------------------------------------------------
module ipol_parse #(
   parameter int ETH_HEADER_BYTES = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output ipol_pkg::result_type  result
);

   localparam logic [7:0] ETH_POS = 8'(ETH_HEADER_BYTES);

   logic [7:0]          pos_ff, pos_in;
   logic [5:0]          outer_hdr_ff, outer_hdr_in;
   logic [5:0]          inner_hdr_ff, inner_hdr_in;
   logic [7:0]          tstart_ff, tstart_in;
   ipol_pkg::phase_type phase_ff, phase_in;
   logic                given_ff, given_in;
   logic                tunnel_ff, tunnel_in;

   logic [5:0] ip_hdr;
   logic [5:0] tcp_hdr;
   logic [7:0] outer_start;
   logic [7:0] inner_start;

   assign ip_hdr      = {data_byte[3:0], 2'b00};
   assign tcp_hdr     = {data_byte[7:4], 2'b00};
   assign outer_start = ETH_POS + {2'b00, outer_hdr_ff};
   assign inner_start = tstart_ff + {2'b00, inner_hdr_ff};

   always_comb begin
      pos_in       = pos_ff;
      outer_hdr_in = outer_hdr_ff;
      inner_hdr_in = inner_hdr_ff;
      tstart_in    = tstart_ff;
      phase_in     = phase_ff;
      given_in     = given_ff;
      tunnel_in    = tunnel_ff;
      result       = '0;

      if (!given_ff) begin
         unique case (phase_ff)
            ipol_pkg::PH_OUTER_IHL: begin
               if (pos_ff == ETH_POS) begin
                  outer_hdr_in = ip_hdr;
                  if (ip_hdr < ipol_pkg::MIN_HDR_BYTES) begin
                     result.valid  = 1'b1;
                     result.status = ipol_pkg::ST_BAD_OUT_IHL;
                  end else begin
                     phase_in = ipol_pkg::PH_OUTER_PROTO;
                  end
               end
            end
            ipol_pkg::PH_OUTER_PROTO: begin
               if (pos_ff == ETH_POS + ipol_pkg::IP_PROTO_POS) begin
                  if (data_byte == ipol_pkg::PROTO_TCP) begin
                     tstart_in = outer_start;
                     phase_in  = ipol_pkg::PH_TCP_OFF;
                  end else if (data_byte == ipol_pkg::PROTO_UDP) begin
                     result.valid            = 1'b1;
                     result.status           = ipol_pkg::ST_OK;
                     result.payload_offset   = outer_start + ipol_pkg::UDP_HDR_BYTES;
                     result.transport_is_udp = 1'b1;
                  end else if (data_byte == ipol_pkg::PROTO_IPIP) begin
                     tunnel_in = 1'b1;
                     tstart_in = outer_start;
                     phase_in  = ipol_pkg::PH_INNER_IHL;
                  end else begin
                     result.valid  = 1'b1;
                     result.status = ipol_pkg::ST_BAD_OUT_PRO;
                  end
               end
            end
            ipol_pkg::PH_INNER_IHL: begin
               if (pos_ff == tstart_ff) begin
                  inner_hdr_in = ip_hdr;
                  if (ip_hdr < ipol_pkg::MIN_HDR_BYTES) begin
                     result.valid  = 1'b1;
                     result.status = ipol_pkg::ST_BAD_IN_IHL;
                  end else begin
                     phase_in = ipol_pkg::PH_INNER_PROTO;
                  end
               end
            end
            ipol_pkg::PH_INNER_PROTO: begin
               if (pos_ff == tstart_ff + ipol_pkg::IP_PROTO_POS) begin
                  if (data_byte == ipol_pkg::PROTO_TCP) begin
                     tstart_in = inner_start;
                     phase_in  = ipol_pkg::PH_TCP_OFF;
                  end else if (data_byte == ipol_pkg::PROTO_UDP) begin
                     result.valid            = 1'b1;
                     result.status           = ipol_pkg::ST_OK;
                     result.payload_offset   = inner_start + ipol_pkg::UDP_HDR_BYTES;
                     result.transport_is_udp = 1'b1;
                  end else begin
                     result.valid  = 1'b1;
                     result.status = ipol_pkg::ST_BAD_IN_PRO;
                  end
               end
            end
            ipol_pkg::PH_TCP_OFF: begin
               if (pos_ff == tstart_ff + ipol_pkg::TCP_OFF_POS) begin
                  result.valid = 1'b1;
                  if (tcp_hdr < ipol_pkg::MIN_HDR_BYTES) begin
                     result.status = ipol_pkg::ST_BAD_TCP_OFF;
                  end else begin
                     result.status         = ipol_pkg::ST_OK;
                     result.payload_offset = tstart_ff + {2'b00, tcp_hdr};
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // short frame
      if (last_byte && !result.valid && !given_ff) begin
         result.valid  = 1'b1;
         result.status = ipol_pkg::ST_TRUNCATED;
      end

      if (result.valid) begin
         given_in = 1'b1;
         phase_in = ipol_pkg::PH_DONE;
      end
      result.tunneled = tunnel_in;

      // end of frame
      if (last_byte) begin
         pos_in       = '0;
         outer_hdr_in = '0;
         inner_hdr_in = '0;
         tstart_in    = '0;
         phase_in     = ipol_pkg::PH_OUTER_IHL;
         given_in     = 1'b0;
         tunnel_in    = 1'b0;
      end else if (pos_ff != ipol_pkg::POS_MAX) begin
         pos_in = pos_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         outer_hdr_ff <= '0;
         inner_hdr_ff <= '0;
         tstart_ff    <= '0;
         phase_ff     <= ipol_pkg::PH_OUTER_IHL;
         given_ff     <= 1'b0;
         tunnel_ff    <= 1'b0;
      end else if (step_en) begin
         pos_ff       <= pos_in;
         outer_hdr_ff <= outer_hdr_in;
         inner_hdr_ff <= inner_hdr_in;
         tstart_ff    <= tstart_in;
         phase_ff     <= phase_in;
         given_ff     <= given_in;
         tunnel_ff    <= tunnel_in;
      end
   end

   a_given_done : assert property (@(posedge clock) disable iff (reset)
      given_ff |-> phase_ff == ipol_pkg::PH_DONE)
      else $error("result given but walk not done");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !given_ff)
      else $error("second result in one frame");

   a_frame_restart : assert property (@(posedge clock) disable iff (reset)
      step_en && last_byte |=> pos_ff == '0 && !given_ff && !tunnel_ff)
      else $error("state not cleared at end of frame");

   a_error_fields : assert property (@(posedge clock) disable iff (reset)
      result.valid && result.status != ipol_pkg::ST_OK
         |-> result.payload_offset == '0 && !result.transport_is_udp)
      else $error("error result carries an offset");

endmodule

// ----- hdl/ip_payload_offset_locator_top.sv -----
// ----------------------------------------------------------------------------
// ip_payload_offset_locator_top
// Finds the payload offset of an IPv4 TCP/UDP frame, IP-in-IP aware.
// ----------------------------------------------------------------------------
// Frame bytes enter one per cycle, starting at the destination MAC. Each
// transaction sits in the input register while the parse step runs; a result
// is registered in the output register as its byte is taken from the input
// register. At most one result per frame, at the byte that settles the payload
// offset or an error, or at the last byte if the frame ends early. Input is
// stalled only while the output register holds a result that is stalled.
module ip_payload_offset_locator_top #(
   parameter int ETH_HEADER_BYTES = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_payload_offset,
   output logic       rsp_transport_is_udp,
   output logic       rsp_tunneled
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   ipol_pkg::result_type rsp_ff;
   ipol_pkg::result_type step_result;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (advance && step_result.valid);

   ipol_parse #(
      .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .data_byte(in_data_ff),
      .last_byte(in_last_ff),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && step_result.valid) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_payload_offset   = rsp_ff.payload_offset;
   assign rsp_transport_is_udp = rsp_ff.transport_is_udp;
   assign rsp_tunneled         = rsp_ff.tunneled;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("held transaction would be overwritten");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && in_valid_ff)
      else $error("input stalled with free output");

   a_result_from_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && step_result.valid))
      else $error("result without a parse step");

endmodule
